// ===== hdl/sliding_iqr_trimmed_mean_defines.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the checker of the trimmed-mean block.
// -----------------------------------------------------------------------------
`ifndef SLIDING_IQR_TRIMMED_MEAN_DEFINES_SVH
`define SLIDING_IQR_TRIMMED_MEAN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sic_pkg.sv =====
// -----------------------------------------------------------------------------
// Trimmed-mean package
// Sizes, quantile positions, controller states and cell controls.
// -----------------------------------------------------------------------------
package sic_pkg;

	localparam int WINDOW_LEN = 30;
	localparam int DATA_W     = 32;
	localparam int PERIOD_W   = 5;
	localparam int OCNT_W     = 5;
	localparam int CNTW       = $clog2(WINDOW_LEN + 1);
	localparam int PHW        = $clog2(WINDOW_LEN);
	localparam int Q1_IDX     = WINDOW_LEN / 4 - 1;
	localparam int Q3_IDX     = (3 * WINDOW_LEN) / 4;
	localparam int SUMW       = DATA_W + $clog2(WINDOW_LEN);
	localparam int MAGW       = SUMW - 1;
	localparam int FENW       = DATA_W + 4;
	localparam int DCW        = $clog2(MAGW + 1);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(5);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CLR   = 8'b0000_0010,
		S_RANK  = 8'b0000_0100,
		S_SEL   = 8'b0000_1000,
		S_FENCE = 8'b0001_0000,
		S_SUM   = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_HOLD  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic en;
		logic cmp;
		logic clr;
	} cell_ctl_t;

endpackage

// ===== hdl/sic_cell.sv =====
// -----------------------------------------------------------------------------
// Window cell
// Holds one sample with its less-than and less-or-equal counts; takes the
// neighbour's sample and counts on every enabled cycle.
// -----------------------------------------------------------------------------
module sic_cell import sic_pkg::*; (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] bcast,
	input  logic signed [DATA_W-1:0] in_val,
	input  logic [CNTW-1:0]          in_lt,
	input  logic [CNTW-1:0]          in_le,
	output logic signed [DATA_W-1:0] val,
	output logic [CNTW-1:0]          lt,
	output logic [CNTW-1:0]          le
);

	logic signed [DATA_W-1:0] val_q;
	logic [CNTW-1:0]          lt_q;
	logic [CNTW-1:0]          le_q;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			lt_q <= '0;
			le_q <= '0;
		end else if (ctl.en) begin
			val_q <= in_val;
			if (ctl.cmp) begin
				lt_q <= in_lt + CNTW'(in_val > bcast);
				le_q <= in_le + CNTW'(in_val >= bcast);
			end else begin
				lt_q <= in_lt;
				le_q <= in_le;
			end
		end
	end

	assign val = val_q;
	assign lt  = lt_q;
	assign le  = le_q;

endmodule

// ===== hdl/sic_div.sv =====
// -----------------------------------------------------------------------------
// Mean divider
// Restoring division of the signed sum by the inlier count, one bit a cycle,
// quotient truncated toward zero.
// -----------------------------------------------------------------------------
module sic_div import sic_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SUMW-1:0]   dividend,
	input  logic [CNTW-1:0]          divisor,
	output logic                     done,
	output logic signed [DATA_W-1:0] quotient
);

	logic            busy_q;
	logic            done_q;
	logic [DCW-1:0]  cnt_q;
	logic [CNTW-1:0] rem_q;
	logic [CNTW-1:0] dvs_q;
	logic [MAGW-1:0] quo_q;
	logic            neg_q;
	logic [CNTW:0]   trial;
	logic            fits;
	logic [SUMW-1:0] mag;

	assign mag   = dividend[SUMW-1] ? -dividend : dividend;
	assign trial = {rem_q, quo_q[MAGW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCW'(MAGW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag[MAGW-1:0];
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[SUMW-1];
		end else if (busy_q) begin
			rem_q <= fits ? CNTW'(trial - {1'b0, dvs_q}) : trial[CNTW-1:0];
			quo_q <= {quo_q[MAGW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -quo_q[DATA_W-1:0] : quo_q[DATA_W-1:0];

endmodule

// ===== hdl/sliding_iqr_trimmed_mean.sv =====
// -----------------------------------------------------------------------------
// Sliding IQR trimmed mean
// Keeps the last samples in a row of cells, ranks them by rotating the row,
// fences out outliers by the interquartile range and divides the inlier sum.
// -----------------------------------------------------------------------------
// An item that ends no period, or arrives before the window is full, leaves the
// controller idle. An item that ends a period starts two rotations of the cell
// row and a one-bit-a-cycle divider, and no item is taken until its result is
// loaded. A result waits in the output register while further items enter.
// Reset clears the fill count, period count and controller; emit_period is 5.
module sliding_iqr_trimmed_mean import sic_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [PERIOD_W-1:0] cfg_wdata,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [31:0]         s_axis_tdata,  // [31:0] sample
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [39:0]         m_axis_tdata   // [31:0] trimmed_mean, [36:32] inlier_count
);

	state_t                   state_q;
	logic [PERIOD_W-1:0]      period_q;
	logic [PERIOD_W-1:0]      pcnt_q;
	logic [CNTW-1:0]          fill_q;
	logic [PHW-1:0]           phase_q;
	logic signed [DATA_W-1:0] q1_q, q3_q;
	logic signed [FENW-1:0]   lo2_q, hi2_q;
	logic signed [SUMW-1:0]   sum_q;
	logic [CNTW-1:0]          icnt_q;
	logic                     ovalid_q;
	logic signed [DATA_W-1:0] omean_q;
	logic [OCNT_W-1:0]        ocnt_q;
	logic                     div_start_s1;

	logic signed [DATA_W-1:0] val [WINDOW_LEN];
	logic [CNTW-1:0]          lt  [WINDOW_LEN];
	logic [CNTW-1:0]          le  [WINDOW_LEN];
	logic signed [DATA_W-1:0] head;
	logic signed [DATA_W-1:0] q1_sel, q3_sel;
	logic signed [FENW-1:0]   x2;
	cell_ctl_t                ctl;
	logic                     accept, rotate, fire, full_next, slot_free;
	logic                     out_load;
	logic [PERIOD_W-1:0]      period_eff;
	logic [PERIOD_W:0]        pnext;
	logic                     div_done;
	logic signed [DATA_W-1:0] div_quo;

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign rotate     = (state_q == S_RANK) || (state_q == S_SUM);
	assign head       = val[WINDOW_LEN-1];
	assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign pnext      = {1'b0, pcnt_q} + 1'b1;
	assign fire       = pnext >= {1'b0, period_eff};
	assign full_next  = (fill_q >= CNTW'(WINDOW_LEN - 1));
	assign slot_free  = !ovalid_q || m_axis_tready;
	assign out_load   = ((state_q == S_DIV && div_done) || state_q == S_HOLD) && slot_free;

	always_comb begin
		ctl.en  = accept || rotate;
		ctl.cmp = (state_q == S_RANK);
		ctl.clr = (state_q == S_CLR);
	end

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		if (i == 0) begin : g_first
			sic_cell u_cell (
				.clk    (clk),
				.ctl    (ctl),
				.bcast  (head),
				.in_val (rotate ? head : s_axis_tdata),
				.in_lt  (lt[WINDOW_LEN-1]),
				.in_le  (le[WINDOW_LEN-1]),
				.val    (val[i]),
				.lt     (lt[i]),
				.le     (le[i])
			);
		end else begin : g_rest
			sic_cell u_cell (
				.clk    (clk),
				.ctl    (ctl),
				.bcast  (head),
				.in_val (val[i-1]),
				.in_lt  (lt[i-1]),
				.in_le  (le[i-1]),
				.val    (val[i]),
				.lt     (lt[i]),
				.le     (le[i])
			);
		end
	end

	always_comb begin
		q1_sel = '0;
		q3_sel = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			if (lt[i] <= CNTW'(Q1_IDX) && le[i] > CNTW'(Q1_IDX))
				q1_sel = q1_sel | val[i];
			if (lt[i] <= CNTW'(Q3_IDX) && le[i] > CNTW'(Q3_IDX))
				q3_sel = q3_sel | val[i];
		end
	end

	assign x2 = FENW'(head) <<< 1;

	sic_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_s1),
		.dividend (sum_q),
		.divisor  (icnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			period_q     <= PERIOD_RESET;
			pcnt_q       <= '0;
			fill_q       <= '0;
			phase_q      <= '0;
			ovalid_q     <= 1'b0;
			div_start_s1 <= 1'b0;
		end else begin
			if (cfg_we)
				period_q <= cfg_wdata;
			if (out_load)
				ovalid_q <= 1'b1;
			else if (ovalid_q && m_axis_tready)
				ovalid_q <= 1'b0;
			div_start_s1 <= (state_q == S_SUM) && (phase_q == PHW'(WINDOW_LEN - 1));
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!full_next)
							fill_q <= fill_q + 1'b1;
						pcnt_q <= fire ? '0 : pnext[PERIOD_W-1:0];
						if (fire && full_next)
							state_q <= S_CLR;
					end
				end
				S_CLR: begin
					phase_q <= '0;
					state_q <= S_RANK;
				end
				S_RANK: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == PHW'(WINDOW_LEN - 1))
						state_q <= S_SEL;
				end
				S_SEL: state_q <= S_FENCE;
				S_FENCE: begin
					phase_q <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == PHW'(WINDOW_LEN - 1))
						state_q <= S_DIV;
				end
				S_DIV, S_HOLD: begin
					if (out_load)
						state_q <= S_IDLE;
					else if (div_done || state_q == S_HOLD)
						state_q <= S_HOLD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SEL) begin
			q1_q <= q1_sel;
			q3_q <= q3_sel;
		end
		if (state_q == S_FENCE) begin
			lo2_q  <= 5 * FENW'(q1_q) - 3 * FENW'(q3_q);
			hi2_q  <= 5 * FENW'(q3_q) - 3 * FENW'(q1_q);
			sum_q  <= '0;
			icnt_q <= '0;
		end
		if (state_q == S_SUM && x2 >= lo2_q && x2 <= hi2_q) begin
			sum_q  <= sum_q + SUMW'(head);
			icnt_q <= icnt_q + 1'b1;
		end
		if (out_load) begin
			omean_q <= div_quo;
			ocnt_q  <= OCNT_W'(icnt_q);
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {3'b000, ocnt_q, omean_q};

endmodule

// ===== hdl/sic_checker.sv =====
// -----------------------------------------------------------------------------
// Trimmed-mean checker
// Port-level properties of the trimmed-mean block, bound to its top level.
// -----------------------------------------------------------------------------
`include "sliding_iqr_trimmed_mean_defines.svh"

module sic_checker import sic_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	`SIC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result item dropped while stalled")
	`SIC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "stalled result item changed")
	`SIC_ASSERT_NOW(a_count_range, m_axis_tvalid, m_axis_tdata[36:32] != 5'd0, "result item with no inliers")
	`SIC_ASSERT_NOW(a_load_after_busy, $rose(m_axis_tvalid), !$past(s_axis_tready), "result item without a computation")

endmodule

bind sliding_iqr_trimmed_mean sic_checker u_sic_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== bench/sliding_iqr_trimmed_mean_checker.sv =====
// -----------------------------------------------------------------------------
// Trimmed-mean checker
// Watches both streams, keeps its own copy of the sample window and period
// count, predicts each outlier-rejected mean and compares every result item.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_iqr_trimmed_mean_checker import sic_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [PERIOD_W-1:0] cfg_wdata,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [31:0]         s_axis_tdata,
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic [39:0]         m_axis_tdata,
	output int                  fail_count,
	output int                  pending,
	output int                  means_seen
);

	typedef struct packed {
		logic signed [31:0] mean;
		logic [4:0]         count;
	} trimmed_t;

	logic signed [31:0]  window_q [WINDOW_LEN];
	int                  wr_pos;
	bit                  filled;
	int                  period_cnt;
	logic [PERIOD_W-1:0] period_reg;
	trimmed_t            expected_means [$];

	function automatic bit trimmed_mean_of(output trimmed_t res);
		longint srt [WINDOW_LEN];
		longint key, q1, q3, iqr, lo2, hi2, sum;
		int j, cnt;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			key = window_q[i];
			j = i;
			while (j > 0 && srt[j-1] > key) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = key;
		end
		q1 = srt[Q1_IDX];
		q3 = srt[Q3_IDX];
		iqr = q3 - q1;
		lo2 = 2 * q1 - 3 * iqr;
		hi2 = 2 * q3 + 3 * iqr;
		sum = 0;
		cnt = 0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			if (2 * srt[i] >= lo2 && 2 * srt[i] <= hi2) begin
				sum += srt[i];
				cnt++;
			end
		end
		if (cnt == 0) return 0;
		res.mean = 32'(sum / longint'(cnt));
		res.count = 5'(cnt);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		trimmed_t exp_r, got;
		int per;
		if (!arst_n) begin
			wr_pos = 0;
			filled = 0;
			period_cnt = 0;
			period_reg = PERIOD_RESET;
			expected_means.delete();
			fail_count = 0;
			pending = 0;
			means_seen = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.mean = m_axis_tdata[31:0];
				got.count = m_axis_tdata[36:32];
				means_seen++;
				if (expected_means.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Unexpected result: mean %0d count %0d", got.mean, got.count);
				end else begin
					exp_r = expected_means.pop_front();
					if (got !== exp_r) begin
						fail_count++;
						if (fail_count <= 10)
							$display("Mismatch: expected mean %0d count %0d, got mean %0d count %0d",
								exp_r.mean, exp_r.count, got.mean, got.count);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				window_q[wr_pos] = s_axis_tdata;
				wr_pos++;
				if (wr_pos >= WINDOW_LEN) begin
					wr_pos = 0;
					filled = 1;
				end
				per = (period_reg == 0) ? 1 : period_reg;
				if (period_cnt + 1 >= per) begin
					period_cnt = 0;
					if (filled && trimmed_mean_of(exp_r))
						expected_means.push_back(exp_r);
				end else begin
					period_cnt++;
				end
			end
			if (cfg_we) period_reg = cfg_wdata;
			pending = expected_means.size();
		end
	end

endmodule

// ===== bench/tb_sliding_iqr_trimmed_mean.sv =====
// -----------------------------------------------------------------------------
// Trimmed-mean testbench
// Drives velocity samples under several emit periods with random gaps and
// back-pressure; the checker predicts and compares every trimmed mean.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_iqr_trimmed_mean import sic_pkg::*;;

	localparam int SLOW_ITEM = 2 * WINDOW_LEN + SUMW + 5;
	localparam int STALL_LIMIT = 20 * SLOW_ITEM;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                cfg_we = 0;
	logic [PERIOD_W-1:0] cfg_wdata = '0;
	logic                s_axis_tvalid = 0;
	logic                s_axis_tready;
	logic [31:0]         s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 0;
	logic [39:0]         m_axis_tdata;
	int                  fail_count, pending, means_seen;
	bit                  quiet = 0;
	bit                  hold_off = 0;
	int                  idle_cycles = 0;
	int                  sent = 0;

	always #1 clk = ~clk;

	sliding_iqr_trimmed_mean dut (.*);
	sliding_iqr_trimmed_mean_checker chk (.*);

	always @(posedge clk) begin
		if (!arst_n || hold_off) begin
			m_axis_tready <= 0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
			m_axis_tready <= 1;
		end else begin
			m_axis_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_sample(input logic [31:0] v);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= v;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	task automatic drain_and_set(input logic [PERIOD_W-1:0] p);
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SLOW_ITEM + 5) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] random_sample(input logic [31:0] base);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return base + 32'($signed($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	initial begin
		logic [31:0] base;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: extremes, bit patterns and outliers under the reset period.
		for (int i = 0; i < 24; i++) begin
			case (i % 6)
				0: send_sample(32'h8000_0000);
				1: send_sample(32'h7FFF_FFFF);
				2: send_sample(32'hFFFF_FFFF);
				3: send_sample(32'h0000_0000);
				4: send_sample(32'hAAAA_AAAA);
				default: send_sample(32'h5555_5555);
			endcase
		end
		drain_and_set(0);
		for (int i = 0; i < 10; i++) send_sample(32'h0001_0000 * i);
		drain_and_set(31);
		for (int i = 0; i < 40; i++) send_sample(i == 7 ? 32'h7FFF_0000 : 32'h0002_0000);
		drain_and_set(1);
		for (int ph = 0; ph < 6; ph++) begin
			base = $urandom;
			for (int i = 0; i < 120; i++) send_sample(random_sample(base));
			drain_and_set(PERIOD_W'(ph == 5 ? 1 : $urandom_range(1, 30)));
		end
		// Long receiver hold-off so the result register fills and input stalls.
		hold_off = 1;
		fork
			begin
				repeat (4 * SLOW_ITEM) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 20; i++) send_sample($urandom);
		join
		drain_and_set(30);
		quiet = 1;
		for (int i = 0; i < 60; i++) send_sample(random_sample(32'h0010_0000));
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (SLOW_ITEM + 10) @(posedge clk);
		$display("Sent %0d samples over periods 0 to 31; %0d trimmed means checked.",
			sent, means_seen);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sic_pkg.sv
hdl/sic_cell.sv
hdl/sic_div.sv
hdl/sliding_iqr_trimmed_mean.sv
hdl/sic_checker.sv
bench/sliding_iqr_trimmed_mean_checker.sv
bench/tb_sliding_iqr_trimmed_mean.sv
